[rtl/tqps_pkg.sv]
// tqps_pkg: shared types, constants and saturating helpers for the two-queue server
// depends on nothing; used by every rtl file through scoped names
`timescale 1ns / 1ps

package tqps_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int LIM_W = (CNT_W > 4) ? CNT_W : 4;

    localparam logic [3:0] LIMIT_RESET = 4'd5;

    localparam logic [1:0] KIND_IDLE = 2'd0;
    localparam logic [1:0] KIND_HIGH = 2'd1;
    localparam logic [1:0] KIND_LOW  = 2'd2;

    typedef struct packed {
        logic [3:0] high_arrivals;
        logic [3:0] low_arrivals;
    } item_t;

    typedef struct packed {
        logic [1:0]  served_kind;
        logic [31:0] served_wait;
        logic [4:0]  refused_now;
        logic [31:0] total_arrivals;
        logic [31:0] high_served_total;
        logic [31:0] low_served_total;
        logic [31:0] refused_total;
        logic [31:0] idle_total;
        logic [47:0] high_wait_sum;
        logic [47:0] low_wait_sum;
        logic [3:0]  high_level;
        logic [3:0]  low_level;
    } result_t;

    // requests from the sequencer to one stamp queue
    typedef struct packed {
        logic push;
        logic pop;
        logic rd;
    } queue_ctrl_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             full;
        logic             empty;
    } queue_status_t;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_HIGH,
        BS_LOW,
        BS_READ,
        BS_SERVE
    } back_state_t;

    function automatic logic [31:0] sat_inc32(input logic [31:0] v);
        logic [32:0] s;
        s = {1'b0, v} + 33'd1;
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic [31:0] sat_add32(input logic [31:0] v, input logic [4:0] a);
        logic [32:0] s;
        s = {1'b0, v} + {28'd0, a};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic [47:0] sat_add48(input logic [47:0] v, input logic [31:0] a);
        logic [48:0] s;
        s = {1'b0, v} + {17'd0, a};
        return s[48] ? 48'hFFFF_FFFF_FFFF : s[47:0];
    endfunction

endpackage

[rtl/tqps_front.sv]
// tqps_front: two-entry input item queue between the item port and the sequencer
// depends on tqps_pkg
`timescale 1ns / 1ps

module tqps_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    output logic           item_stall,
    input  tqps_pkg::item_t item_data,
    output logic           head_valid,
    output tqps_pkg::item_t head_data,
    input  logic           head_pop
);

    tqps_pkg::item_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       push;
    logic       pop;

    assign item_stall = (fill_reg == 2'd2);
    assign push       = item_valid && !item_stall;
    assign head_valid = (fill_reg != 2'd0);
    assign head_data  = entry_reg[rd_ptr_reg];
    assign pop        = head_pop && head_valid;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= item_data;
        end
    end

endmodule

[rtl/tqps_queue.sv]
// tqps_queue: one timestamp queue, a small memory with head, tail and count
// depends on tqps_pkg
`timescale 1ns / 1ps

module tqps_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [3:0]             limit,
    input  tqps_pkg::queue_ctrl_t  ctrl,
    input  logic [31:0]            push_stamp,
    output tqps_pkg::queue_status_t status,
    output logic [31:0]            head_stamp
);

    logic [31:0] mem [tqps_pkg::QUEUE_DEPTH];
    logic [31:0] rdata_reg;

    logic [tqps_pkg::IDX_W-1:0] head_reg, head_next;
    logic [tqps_pkg::IDX_W-1:0] tail_reg, tail_next;
    logic [tqps_pkg::CNT_W-1:0] count_reg, count_next;

    localparam logic [tqps_pkg::IDX_W-1:0] LAST_IDX =
        tqps_pkg::IDX_W'(tqps_pkg::QUEUE_DEPTH - 1);
    localparam logic [tqps_pkg::CNT_W-1:0] DEPTH_CNT =
        tqps_pkg::CNT_W'(tqps_pkg::QUEUE_DEPTH);

    // count never exceeds the depth, so this is count >= min(limit, depth)
    always_comb
    begin
        status.count = count_reg;
        status.empty = (count_reg == '0);
        status.full  = (tqps_pkg::LIM_W'(count_reg) >= tqps_pkg::LIM_W'(limit)) ||
                       (count_reg == DEPTH_CNT);
    end

    assign head_stamp = rdata_reg;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (ctrl.push)
        begin
            tail_next = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
        end
        if (ctrl.pop)
        begin
            head_next = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
        end
        count_next = count_reg + tqps_pkg::CNT_W'(ctrl.push) - tqps_pkg::CNT_W'(ctrl.pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            mem[tail_reg] <= push_stamp;
        end
        if (ctrl.rd)
        begin
            rdata_reg <= mem[head_reg];
        end
    end

endmodule

[rtl/tqps_back.sv]
// tqps_back: per-tick sequencer, enqueues arrivals one a cycle, serves at most one request,
// keeps the running totals and the result register; depends on tqps_pkg and tqps_queue
`timescale 1ns / 1ps

module tqps_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    input  logic [3:0]       cfg_data,
    input  logic             head_valid,
    input  tqps_pkg::item_t  head_data,
    output logic             head_pop,
    output logic             result_valid,
    input  logic             result_stall,
    output tqps_pkg::result_t result_data
);

    tqps_pkg::back_state_t state_reg, state_next;

    logic [3:0]  limit_reg, limit_next;
    logic [31:0] tick_reg, tick_next;
    logic [3:0]  hrem_reg, hrem_next;
    logic [3:0]  lrem_reg, lrem_next;
    logic [4:0]  refused_reg, refused_next;

    logic [31:0] arr_reg, arr_next;
    logic [31:0] hs_reg, hs_next;
    logic [31:0] ls_reg, ls_next;
    logic [31:0] ref_reg, ref_next;
    logic [31:0] idle_reg, idle_next;
    logic [47:0] hw_reg, hw_next;
    logic [47:0] lw_reg, lw_next;

    tqps_pkg::result_t result_reg, result_next;
    logic              result_valid_reg, result_valid_next;

    tqps_pkg::queue_ctrl_t   hi_ctrl, lo_ctrl;
    tqps_pkg::queue_status_t hi_status, lo_status;
    logic [31:0]             hi_stamp, lo_stamp;

    logic        out_free;
    logic [31:0] wait_val;
    logic [1:0]  kind;
    logic [tqps_pkg::CNT_W-1:0] hi_after, lo_after;

    tqps_queue u_high (
        .clk        (clk),
        .rst_n      (rst_n),
        .limit      (limit_reg),
        .ctrl       (hi_ctrl),
        .push_stamp (tick_reg),
        .status     (hi_status),
        .head_stamp (hi_stamp)
    );

    tqps_queue u_low (
        .clk        (clk),
        .rst_n      (rst_n),
        .limit      (limit_reg),
        .ctrl       (lo_ctrl),
        .push_stamp (tick_reg),
        .status     (lo_status),
        .head_stamp (lo_stamp)
    );

    assign out_free     = !result_valid_reg || !result_stall;
    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;

    always_comb
    begin
        state_next        = state_reg;
        limit_next        = cfg_valid ? cfg_data : limit_reg;
        tick_next         = tick_reg;
        hrem_next         = hrem_reg;
        lrem_next         = lrem_reg;
        refused_next      = refused_reg;
        arr_next          = arr_reg;
        hs_next           = hs_reg;
        ls_next           = ls_reg;
        ref_next          = ref_reg;
        idle_next         = idle_reg;
        hw_next           = hw_reg;
        lw_next           = lw_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;
        head_pop          = 1'b0;
        hi_ctrl           = '0;
        lo_ctrl           = '0;
        wait_val          = 32'd0;
        kind              = tqps_pkg::KIND_IDLE;
        hi_after          = hi_status.count;
        lo_after          = lo_status.count;

        case (state_reg)
            tqps_pkg::BS_IDLE:
            begin
                if (head_valid)
                begin
                    head_pop     = 1'b1;
                    tick_next    = tick_reg + 32'd1;
                    hrem_next    = head_data.high_arrivals;
                    lrem_next    = head_data.low_arrivals;
                    refused_next = 5'd0;
                    state_next   = tqps_pkg::BS_HIGH;
                end
            end
            tqps_pkg::BS_HIGH:
            begin
                if (hrem_reg == 4'd0)
                begin
                    state_next = tqps_pkg::BS_LOW;
                end
                else
                begin
                    arr_next  = tqps_pkg::sat_inc32(arr_reg);
                    hrem_next = hrem_reg - 4'd1;
                    if (hi_status.full)
                    begin
                        refused_next = refused_reg + 5'd1;
                    end
                    else
                    begin
                        hi_ctrl.push = 1'b1;
                    end
                end
            end
            tqps_pkg::BS_LOW:
            begin
                if (lrem_reg == 4'd0)
                begin
                    state_next = tqps_pkg::BS_READ;
                end
                else
                begin
                    arr_next  = tqps_pkg::sat_inc32(arr_reg);
                    lrem_next = lrem_reg - 4'd1;
                    if (lo_status.full)
                    begin
                        refused_next = refused_reg + 5'd1;
                    end
                    else
                    begin
                        lo_ctrl.push = 1'b1;
                    end
                end
            end
            tqps_pkg::BS_READ:
            begin
                // both heads are fetched, the serve step picks one
                hi_ctrl.rd = 1'b1;
                lo_ctrl.rd = 1'b1;
                state_next = tqps_pkg::BS_SERVE;
            end
            tqps_pkg::BS_SERVE:
            begin
                if (out_free)
                begin
                    ref_next = tqps_pkg::sat_add32(ref_reg, refused_reg);
                    if (!hi_status.empty)
                    begin
                        kind        = tqps_pkg::KIND_HIGH;
                        wait_val    = tick_reg - hi_stamp;
                        hi_ctrl.pop = 1'b1;
                        hi_after    = hi_status.count - 1'b1;
                        hw_next     = tqps_pkg::sat_add48(hw_reg, wait_val);
                        hs_next     = tqps_pkg::sat_inc32(hs_reg);
                    end
                    else if (!lo_status.empty)
                    begin
                        kind        = tqps_pkg::KIND_LOW;
                        wait_val    = tick_reg - lo_stamp;
                        lo_ctrl.pop = 1'b1;
                        lo_after    = lo_status.count - 1'b1;
                        lw_next     = tqps_pkg::sat_add48(lw_reg, wait_val);
                        ls_next     = tqps_pkg::sat_inc32(ls_reg);
                    end
                    else
                    begin
                        idle_next = tqps_pkg::sat_inc32(idle_reg);
                    end
                    result_next.served_kind       = kind;
                    result_next.served_wait       = wait_val;
                    result_next.refused_now       = refused_reg;
                    result_next.total_arrivals    = arr_reg;
                    result_next.high_served_total = hs_next;
                    result_next.low_served_total  = ls_next;
                    result_next.refused_total     = ref_next;
                    result_next.idle_total        = idle_next;
                    result_next.high_wait_sum     = hw_next;
                    result_next.low_wait_sum      = lw_next;
                    result_next.high_level        = 4'(hi_after);
                    result_next.low_level         = 4'(lo_after);
                    result_valid_next             = 1'b1;
                    state_next                    = tqps_pkg::BS_IDLE;
                end
            end
            default:
            begin
                state_next = tqps_pkg::BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= tqps_pkg::BS_IDLE;
            limit_reg        <= tqps_pkg::LIMIT_RESET;
            tick_reg         <= 32'd0;
            hrem_reg         <= 4'd0;
            lrem_reg         <= 4'd0;
            refused_reg      <= 5'd0;
            arr_reg          <= 32'd0;
            hs_reg           <= 32'd0;
            ls_reg           <= 32'd0;
            ref_reg          <= 32'd0;
            idle_reg         <= 32'd0;
            hw_reg           <= 48'd0;
            lw_reg           <= 48'd0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            limit_reg        <= limit_next;
            tick_reg         <= tick_next;
            hrem_reg         <= hrem_next;
            lrem_reg         <= lrem_next;
            refused_reg      <= refused_next;
            arr_reg          <= arr_next;
            hs_reg           <= hs_next;
            ls_reg           <= ls_next;
            ref_reg          <= ref_next;
            idle_reg         <= idle_next;
            hw_reg           <= hw_next;
            lw_reg           <= lw_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

endmodule

[rtl/two_queue_priority_server_top.sv]
// two_queue_priority_server_top: one tick per item, one result per item
// an item passes the front queue, then the sequencer's idle, high, low, read and serve states
// the sequencer enqueues one arrival a cycle and works on one item at a time; later items wait in front
// a two-entry item queue in front keeps accepting, until full, while the sequencer or the result waits
// reset: rst_n asynchronous active low; clears counters, tick, queue pointers, limit to 5
`timescale 1ns / 1ps

module two_queue_priority_server_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  tqps_pkg::item_t   item_data,
    output logic              result_valid,
    input  logic              result_stall,
    output tqps_pkg::result_t result_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [3:0]        cfg_data
);

    logic            head_valid;
    tqps_pkg::item_t head_data;
    logic            head_pop;

    assign cfg_ready = 1'b1;

    tqps_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item_data  (item_data),
        .head_valid (head_valid),
        .head_data  (head_data),
        .head_pop   (head_pop)
    );

    tqps_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .head_valid   (head_valid),
        .head_data    (head_data),
        .head_pop     (head_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

endmodule

[rtl/tqps_checker.sv]
// tqps_checker: port-level checks on the two-queue server, bound to the top level
// depends on tqps_pkg and two_queue_priority_server_top
`timescale 1ns / 1ps

module tqps_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              result_valid,
    input logic              result_stall,
    input tqps_pkg::result_t result_data
);

    // an idle tick reports no wait
    a_idle_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_data.served_kind == tqps_pkg::KIND_IDLE)
            |-> result_data.served_wait == 32'd0)
        else $error("idle result with nonzero wait");

    a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result_data.served_kind == tqps_pkg::KIND_IDLE ||
                          result_data.served_kind == tqps_pkg::KIND_HIGH ||
                          result_data.served_kind == tqps_pkg::KIND_LOW))
        else $error("bad served kind");

    // levels never exceed the queue depth
    a_levels: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (32'(result_data.high_level) <= tqps_pkg::QUEUE_DEPTH &&
                          32'(result_data.low_level) <= tqps_pkg::QUEUE_DEPTH))
        else $error("queue level above depth");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (result_valid && $stable(result_data)))
        else $error("stalled result changed");

endmodule

bind two_queue_priority_server_top tqps_checker u_tqps_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
);
